FILE: rtl/slfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver package
// Shared types and constants for the sync-word, length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

   localparam int HdrLen     = 6;
   localparam int MaxResults = 64;

   localparam logic [6:0]  AppBufReset = 7'd64;
   localparam logic [31:0] SyncReset   = 32'h4142_4344;

   localparam logic CsrAppBufSize = 1'b0;
   localparam logic CsrSyncWord   = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_SYNC   = 2'd1,
      ERR_LENGTH = 2'd2
   } err_code_type;

   typedef enum logic [1:0] {
      ST_RX,
      ST_RD,
      ST_WR
   } state_type;

   typedef struct packed {
      logic         take;
      logic         hunt;
      logic         load_err;
      err_code_type err_code;
      logic         drain_start;
      logic         read;
      logic         emit;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic in_header;
      logic sixth;
      logic sync_ok;
      logic len_bad;
      logic header_bad;
      logic pay_last;
      logic n_zero;
      logic drain_last;
   } sts_type;

endpackage

FILE: rtl/slfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver controller
// Sequences byte intake, error results and the drain of the payload store.
// ----------------------------------------------------------------------------
module slfr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  slfr_pkg::sts_type sts,
   output slfr_pkg::cmd_type cmd
);

   slfr_pkg::state_type state_ff;
   slfr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slfr_pkg::ST_RX;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.err_code = slfr_pkg::ERR_NONE;
      req_tready   = 1'b0;
      unique case (state_ff)
         slfr_pkg::ST_RX: begin
            req_tready = sts.slot_free;
            if (req_tvalid && sts.slot_free) begin
               cmd.take = 1'b1;
               priority if (sts.in_header) begin
                  if (sts.sixth && sts.sync_ok && sts.len_bad) begin
                     cmd.load_err = 1'b1;
                     cmd.err_code = slfr_pkg::ERR_LENGTH;
                     cmd.hunt     = 1'b1;
                  end
               end else if (sts.header_bad) begin
                  cmd.load_err = 1'b1;
                  cmd.err_code = slfr_pkg::ERR_SYNC;
                  cmd.hunt     = 1'b1;
               end else if (sts.pay_last) begin
                  cmd.hunt = 1'b1;
                  if (!sts.n_zero) begin
                     cmd.drain_start = 1'b1;
                     state_in        = slfr_pkg::ST_RD;
                  end
               end
            end
         end
         slfr_pkg::ST_RD: begin
            cmd.read = 1'b1;
            state_in = slfr_pkg::ST_WR;
         end
         slfr_pkg::ST_WR: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               state_in = sts.drain_last ? slfr_pkg::ST_RX : slfr_pkg::ST_RD;
            end
         end
         default: begin
            state_in = slfr_pkg::ST_RX;
         end
      endcase
   end

endmodule

FILE: rtl/slfr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver datapath
// Header capture and checks, payload store, drain counter, output register.
// ----------------------------------------------------------------------------
module slfr_datapath #(
   parameter int PAYLOAD_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [31:0]      csr_data,
   input  logic [7:0]       req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output logic [1:0]       rsp_tuser,
   input  slfr_pkg::cmd_type cmd,
   output slfr_pkg::sts_type sts
);

   localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int CW = $clog2(PAYLOAD_DEPTH + 7);
   localparam int LW = $clog2(PAYLOAD_DEPTH + 1);
   localparam int ND = (PAYLOAD_DEPTH < slfr_pkg::MaxResults) ?
                       PAYLOAD_DEPTH : slfr_pkg::MaxResults;
   localparam int NW = $clog2(ND + 1);
   localparam int MW = (LW > 7) ? LW : 7;

   logic [6:0]    app_size_ff;
   logic [31:0]   sync_word_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          header_bad_ff;
   logic          header_bad_in;
   logic [LW-1:0] length_ff;
   logic [LW-1:0] length_in;
   logic [7:0]    hdr_ff [5];
   logic [7:0]    mem [PAYLOAD_DEPTH];
   logic [7:0]    rdata_ff;
   logic [NW-1:0] k_ff;
   logic [NW-1:0] n_ff;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_data_ff;
   logic          rsp_last_ff;
   logic [1:0]    rsp_err_ff;

   logic [15:0]   len16;
   logic [CW-1:0] pos;
   logic [MW-1:0] app_ext;
   logic [MW-1:0] len_ext;
   logic [MW-1:0] min1;
   logic [MW-1:0] min2;
   logic [NW-1:0] n_calc;
   logic          drain_last;
   logic          pay_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         app_size_ff  <= slfr_pkg::AppBufReset;
         sync_word_ff <= slfr_pkg::SyncReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            slfr_pkg::CsrAppBufSize: app_size_ff  <= csr_data[6:0];
            slfr_pkg::CsrSyncWord:   sync_word_ff <= csr_data;
         endcase
      end
   end

   assign len16 = {hdr_ff[4], req_tdata};
   assign pos   = count_ff - CW'(slfr_pkg::HdrLen);

   assign app_ext = MW'(app_size_ff);
   assign len_ext = MW'(length_ff);
   assign min1    = (app_ext < len_ext) ? app_ext : len_ext;
   assign min2    = (min1 < MW'(ND)) ? min1 : MW'(ND);
   assign n_calc  = NW'(min2);

   assign drain_last = (k_ff + NW'(1)) == n_ff;
   assign pay_take   = cmd.take && !sts.in_header && !header_bad_ff;

   always_comb begin
      sts.slot_free  = !rsp_valid_ff || rsp_tready;
      sts.in_header  = count_ff < CW'(slfr_pkg::HdrLen);
      sts.sixth      = count_ff == CW'(slfr_pkg::HdrLen - 1);
      sts.sync_ok    = {hdr_ff[0], hdr_ff[1], hdr_ff[2], hdr_ff[3]} == sync_word_ff;
      sts.len_bad    = (len16 == 16'd0) || (len16 > 16'(PAYLOAD_DEPTH));
      sts.header_bad = header_bad_ff;
      sts.pay_last   = (count_ff - CW'(slfr_pkg::HdrLen - 1)) == CW'(length_ff);
      sts.n_zero     = n_calc == '0;
      sts.drain_last = drain_last;
   end

   always_comb begin
      count_in      = count_ff;
      header_bad_in = header_bad_ff;
      length_in     = length_ff;
      if (cmd.take) begin
         count_in = count_ff + CW'(1);
         if (sts.sixth) begin
            header_bad_in = !sts.sync_ok;
            if (sts.sync_ok) begin
               length_in = LW'(len16);
            end
         end
      end
      if (cmd.hunt) begin
         count_in      = '0;
         header_bad_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         header_bad_ff <= 1'b0;
         length_ff     <= '0;
      end else begin
         count_ff      <= count_in;
         header_bad_ff <= header_bad_in;
         length_ff     <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && count_ff < CW'(slfr_pkg::HdrLen - 1)) begin
         hdr_ff[count_ff[2:0]] <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (pay_take) begin
         mem[AW'(pos)] <= req_tdata;
      end
      if (cmd.read) begin
         rdata_ff <= mem[AW'(k_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.drain_start) begin
         k_ff <= '0;
         n_ff <= n_calc;
      end else if (cmd.emit) begin
         k_ff <= k_ff + NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_err || cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_err) begin
         rsp_data_ff <= 8'd0;
         rsp_last_ff <= 1'b1;
         rsp_err_ff  <= cmd.err_code;
      end else if (cmd.emit) begin
         rsp_data_ff <= rdata_ff;
         rsp_last_ff <= drain_last;
         rsp_err_ff  <= slfr_pkg::ERR_NONE;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

FILE: rtl/sync_length_frame_receiver.sv
`timescale 1ns / 1ps
// Header and payload bytes are accepted while the output register is free; an error
// result is valid the cycle after the byte that causes it. After the last payload byte,
// input stalls while the store is drained through its single registered read port: each
// byte is read into the read register, then moves to the output register once it is free.
// Reset is synchronous and active high; it restores the register defaults and the hunt
// state. The payload store is not cleared.
// ----------------------------------------------------------------------------
// Sync-word, length-prefixed frame receiver
// Checks a four-byte sync pattern and a 16-bit length, buffers the payload and
// delivers up to the configured number of bytes per frame.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver #(
   parameter int PAYLOAD_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] payload_byte
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // [1:0] error_code
);

   slfr_pkg::cmd_type cmd;
   slfr_pkg::sts_type sts;

   slfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   slfr_datapath #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

FILE: rtl/slfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Checks result channel behavior as seen on the top level ports.
// ----------------------------------------------------------------------------
module slfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic        csr_index,
   input logic [31:0] csr_data,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != slfr_pkg::ERR_NONE |-> rsp_tdata == 8'd0 && rsp_tlast)
      else $error("error result is not a zero last transfer");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind sync_length_frame_receiver slfr_checker u_slfr_checker (.*);

FILE: dv/tb_sync_length_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Streams sync-word, length-prefixed frames, bad headers and stray bytes into
// the receiver under several register settings and random handshake gaps. A
// behavioral copy of the receiver predicts every delivered byte and error.
// ----------------------------------------------------------------------------
module tb_sync_length_frame_receiver;

   localparam int PayloadDepth = 64;
   localparam int DrainGap     = 200;
   localparam int CycleLimit   = 1_000_000;
   localparam int HoldCycles   = 400;

   typedef struct packed {
      logic [7:0]             data;
      logic                   last;
      slfr_pkg::err_code_type err;
   } frame_rsp_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = slfr_pkg::CsrAppBufSize;
   logic [31:0] csr_data   = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   logic [7:0]    link_bytes_q[$];
   frame_rsp_type frame_rsp_q[$];
   frame_rsp_type rsp_want;

   int snd_idle_pct   = 0;
   int rcv_idle_pct   = 0;
   int queued_bytes   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int hold_left      = 0;
   bit hold_arm       = 1'b0;
   bit hold_done      = 1'b0;

   logic [6:0]  cfg_app_buf = slfr_pkg::AppBufReset;
   logic [31:0] cfg_sync    = slfr_pkg::SyncReset;
   int          rx_count    = 0;
   logic [7:0]  hdr_bytes[slfr_pkg::HdrLen];
   logic [7:0]  pay_store[PayloadDepth];
   logic [15:0] pay_len     = '0;
   logic        sync_miss   = 1'b0;

   sync_length_frame_receiver #(
      .PAYLOAD_DEPTH(PayloadDepth)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_rsp(logic [7:0] data, logic last,
                                    slfr_pkg::err_code_type err);
      frame_rsp_type r;
      r.data = data;
      r.last = last;
      r.err  = err;
      frame_rsp_q.push_back(r);
   endfunction

   function automatic void absorb_rx_byte(logic [7:0] b);
      int pos;
      int n;
      if (rx_count < slfr_pkg::HdrLen) begin
         hdr_bytes[rx_count] = b;
         rx_count++;
         if (rx_count == slfr_pkg::HdrLen) begin
            sync_miss = {hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]} != cfg_sync;
            if (!sync_miss) begin
               pay_len = {hdr_bytes[4], hdr_bytes[5]};
               if (pay_len == 0 || pay_len > PayloadDepth) begin
                  push_rsp(8'h00, 1'b1, slfr_pkg::ERR_LENGTH);
                  rx_count = 0;
               end
            end
         end
      end else if (sync_miss) begin
         push_rsp(8'h00, 1'b1, slfr_pkg::ERR_SYNC);
         rx_count  = 0;
         sync_miss = 1'b0;
      end else begin
         pos = rx_count - slfr_pkg::HdrLen;
         pay_store[pos] = b;
         rx_count++;
         if (pos + 1 >= pay_len) begin
            n = cfg_app_buf;
            if (pay_len < n) n = pay_len;
            if (n > slfr_pkg::MaxResults) n = slfr_pkg::MaxResults;
            if (n > PayloadDepth) n = PayloadDepth;
            for (int k = 0; k < n; k++) begin
               push_rsp(pay_store[k], k + 1 == n, slfr_pkg::ERR_NONE);
            end
            rx_count = 0;
         end
      end
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL sync_length_frame_receiver");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_rx_byte(req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (link_bytes_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= link_bytes_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= hold_left == 0 && $urandom_range(99) >= rcv_idle_pct;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_rsp_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected transfer data=%02h last=%0d err=%0d",
                                    rsp_tdata, rsp_tlast, rsp_tuser));
         end else begin
            rsp_want = frame_rsp_q.pop_front();
            if (rsp_tdata !== rsp_want.data || rsp_tlast !== rsp_want.last ||
                rsp_tuser !== rsp_want.err) begin
               flag_mismatch($sformatf("got data=%02h last=%0d err=%0d, want %02h %0d %0d",
                                       rsp_tdata, rsp_tlast, rsp_tuser,
                                       rsp_want.data, rsp_want.last, rsp_want.err));
            end
         end
      end
   end

   task automatic csr_write(input logic index, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == slfr_pkg::CsrAppBufSize) begin
         cfg_app_buf = data[6:0];
      end else begin
         cfg_sync = data;
      end
      @(negedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] b);
      link_bytes_q.push_back(b);
      queued_bytes++;
   endtask

   task automatic queue_header(input logic [31:0] sync, input logic [15:0] len);
      queue_byte(sync[31:24]);
      queue_byte(sync[23:16]);
      queue_byte(sync[15:8]);
      queue_byte(sync[7:0]);
      queue_byte(len[15:8]);
      queue_byte(len[7:0]);
   endtask

   task automatic queue_frame(input logic [15:0] len);
      queue_header(cfg_sync, len);
      if (len >= 1 && len <= PayloadDepth) begin
         repeat (len) queue_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic queue_bad_sync();
      queue_header(cfg_sync ^ (32'd1 << $urandom_range(31)), 16'($urandom_range(65535)));
      queue_byte(8'($urandom_range(255)));
   endtask

   function automatic logic [15:0] pick_len();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 16'($urandom_range(1, 8));
      if (r < 82) return 16'($urandom_range(9, 63));
      if (r < 90) return 16'(PayloadDepth);
      if (r < 94) return 16'(PayloadDepth + 1);
      if (r < 97) return 16'd0;
      return 16'($urandom_range(PayloadDepth + 1, 65535));
   endfunction

   task automatic run_random(input int nbytes);
      int stop;
      int pick;
      stop = queued_bytes + nbytes;
      while (queued_bytes < stop) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            queue_frame(pick_len());
         end else if (pick < 95) begin
            queue_bad_sync();
         end else begin
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(255)));
         end
      end
   endtask

   task automatic wait_quiet();
      while (link_bytes_q.size() != 0 || req_tvalid || frame_rsp_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Stray bytes can leave the receiver mid-frame, so it is fed filler until it
   // is back at the start of a frame before any register changes.
   task automatic close_phase();
      wait_quiet();
      while (rx_count != 0) begin
         queue_byte(8'($urandom_range(255)));
         wait_quiet();
      end
      repeat (DrainGap) @(negedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      snd_idle_pct = 12;
      rcv_idle_pct = 64;
      queue_header(cfg_sync, 16'd1);
      queue_byte(8'hFF);
      queue_header(cfg_sync, 16'd0);
      queue_header(cfg_sync, 16'hFFFF);
      queue_header(~cfg_sync, 16'd0);
      queue_byte(8'h00);
      run_random(32);
      close_phase();

      csr_write(slfr_pkg::CsrAppBufSize, 32'd1);
      csr_write(slfr_pkg::CsrSyncWord, $urandom);
      run_random(32);
      close_phase();

      snd_idle_pct = 64;
      rcv_idle_pct = 12;
      csr_write(slfr_pkg::CsrAppBufSize, 32'd0);
      csr_write(slfr_pkg::CsrSyncWord, 32'hFFFF_FFFF);
      run_random(32);
      close_phase();

      csr_write(slfr_pkg::CsrAppBufSize, 32'd127);
      csr_write(slfr_pkg::CsrSyncWord, 32'h0000_0000);
      run_random(32);
      close_phase();

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      csr_write(slfr_pkg::CsrAppBufSize, 32'($urandom_range(2, 63)));
      csr_write(slfr_pkg::CsrSyncWord, slfr_pkg::SyncReset);
      hold_arm = 1'b1;
      repeat (2) queue_frame(16'd24);
      run_random(32);
      close_phase();

      if (mismatch_count == 0) begin
         $display("PASS sync_length_frame_receiver");
      end else begin
         $display("FAIL sync_length_frame_receiver");
      end
      $finish;
   end

endmodule

FILE: sync_length_frame_receiver.f
rtl/slfr_pkg.sv
rtl/slfr_ctrl.sv
rtl/slfr_datapath.sv
rtl/sync_length_frame_receiver.sv
rtl/slfr_checker.sv
dv/tb_sync_length_frame_receiver.sv
